// ===== hdl/assert_macros.svh =====
// Assertion macros used by the RTL of the timer queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/dotq_pkg.sv =====
// Types and constants of the deadline-ordered timer queue.
`default_nettype none

package dotq_pkg;

    // Queue sizing
    localparam int CAPACITY = 16;
    localparam int MAX_FIRE = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int PTR_W    = $clog2(CAPACITY);
    localparam int FIRE_W   = $clog2(MAX_FIRE + 1);

    // Field widths
    localparam int TIME_W   = 32;
    localparam int ID_W     = 16;
    localparam int HANDLE_W = 16;
    localparam int TOPIC_W  = 8;
    localparam int DELAY_W  = 24;

    typedef enum logic [1:0] {
        ACT_SCHEDULE = 2'd0,
        ACT_CANCEL   = 2'd1,
        ACT_TICK     = 2'd2,
        ACT_CLEAR    = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        KIND_ACCEPTED = 3'd0,
        KIND_FULL     = 3'd1,
        KIND_CANCEL   = 3'd2,
        KIND_CLEARED  = 3'd3,
        KIND_FIRED    = 3'd4,
        KIND_NONE     = 3'd5
    } kind_t;

    // One stored timer entry
    typedef struct packed {
        logic [TIME_W-1:0]   deadline;
        logic [ID_W-1:0]     id;
        logic [HANDLE_W-1:0] handle;
        logic [TOPIC_W-1:0]  topic;
    } entry_t;

    // One result beat
    typedef struct packed {
        kind_t               kind;
        logic [ID_W-1:0]     result_id;
        logic [HANDLE_W-1:0] fired_handle;
        logic [TOPIC_W-1:0]  fired_topic;
        logic                found;
        logic                last;
    } result_t;

endpackage

`default_nettype wire

// ===== hdl/dotq_cmd_if.sv =====
// Command channel of the timer queue: valid/ready plus one action beat.
`default_nettype none

interface dotq_cmd_if;
    import dotq_pkg::*;

    logic                valid;
    logic                ready;
    action_t             action;
    logic [HANDLE_W-1:0] event_handle;
    logic [TOPIC_W-1:0]  topic;
    logic [DELAY_W-1:0]  delay;
    logic [ID_W-1:0]     target_id;

    modport source (
        output valid, action, event_handle, topic, delay, target_id,
        input  ready
    );

    modport sink (
        input  valid, action, event_handle, topic, delay, target_id,
        output ready
    );
endinterface

`default_nettype wire

// ===== hdl/dotq_res_if.sv =====
// Result channel of the timer queue: valid/ready plus one result beat.
`default_nettype none

interface dotq_res_if;
    import dotq_pkg::*;

    logic                valid;
    logic                ready;
    kind_t               kind;
    logic [ID_W-1:0]     result_id;
    logic [HANDLE_W-1:0] fired_handle;
    logic [TOPIC_W-1:0]  fired_topic;
    logic                found;
    logic                last;

    modport source (
        output valid, kind, result_id, fired_handle, fired_topic, found, last,
        input  ready
    );

    modport sink (
        input  valid, kind, result_id, fired_handle, fired_topic, found, last,
        output ready
    );
endinterface

`default_nettype wire

// ===== hdl/deadline_ordered_timer_queue_core.sv =====
// One command at a time: schedule scans for the insert place, opens a gap and writes the entry,
// or answers full at once; cancel scans for the id and closes the hole, or answers on a miss;
// clear answers at once; tick pops due entries from the front, at most sixteen, a beat each.
// The next command is taken the cycle after the final result is loaded; the ring store (one
// read, one write a cycle) walked by the sequencer bounds these sequences.
// Reset (async, active low) clears all sequencer and output registers, not the ring store.
`default_nettype none
`include "assert_macros.svh"

module deadline_ordered_timer_queue_core (
    input  logic          clk,
    input  logic          rst_n,
    dotq_cmd_if.sink      cmd,
    dotq_res_if.source    evt
);
    import dotq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH,
        S_SHUP,
        S_INS,
        S_SHDN,
        S_T_RD,
        S_T_CHK,
        S_T_END,
        S_DONE
    } state_t;

    // Wrap-safe "a strictly before b"
    function automatic logic earlier(input logic [TIME_W-1:0] a,
                                     input logic [TIME_W-1:0] b);
        logic [TIME_W-1:0] d;
        d = a - b;
        return d[TIME_W-1];
    endfunction

    // Ring address of logical slot off from base
    function automatic logic [PTR_W-1:0] phys(input logic [PTR_W-1:0] base,
                                              input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
        if (sum >= (CNT_W+1)'(CAPACITY))
        begin
            sum = sum - (CNT_W+1)'(CAPACITY);
        end
        return sum[PTR_W-1:0];
    endfunction

    function automatic result_t mk_res(input kind_t k, input logic [ID_W-1:0] id,
                                       input logic [HANDLE_W-1:0] h,
                                       input logic [TOPIC_W-1:0] t,
                                       input logic f, input logic l);
        result_t r;
        r.kind         = k;
        r.result_id    = id;
        r.fired_handle = h;
        r.fired_topic  = t;
        r.found        = f;
        r.last         = l;
        return r;
    endfunction

    // Ring store
    entry_t mem [CAPACITY];
    entry_t rd_data_reg;

    logic             rd_en;
    logic [PTR_W-1:0] rd_addr;
    logic             wr_en;
    logic [PTR_W-1:0] wr_addr;
    entry_t           wr_data;

    // Sequencer state
    state_t              state_reg,   state_next;
    action_t             op_reg,      op_next;
    logic [TIME_W-1:0]   now_reg,     now_next;
    logic [ID_W-1:0]     next_id_reg, next_id_next;
    logic [CNT_W-1:0]    cnt_reg,     cnt_next;
    logic [PTR_W-1:0]    head_reg,    head_next;
    logic [TIME_W-1:0]   dl_reg,      dl_next;
    logic [ID_W-1:0]     tgt_reg,     tgt_next;
    logic [HANDLE_W-1:0] hnd_reg,     hnd_next;
    logic [TOPIC_W-1:0]  top_reg,     top_next;
    logic [CNT_W-1:0]    idx_reg,     idx_next;
    logic                cmp_v_reg,   cmp_v_next;
    logic [CNT_W-1:0]    cmp_idx_reg, cmp_idx_next;
    logic [CNT_W-1:0]    pos_reg,     pos_next;
    logic                wr_v_reg,    wr_v_next;
    logic [CNT_W-1:0]    wr_idx_reg,  wr_idx_next;
    logic [FIRE_W-1:0]   fire_n_reg,  fire_n_next;
    logic                pend_v_reg,  pend_v_next;
    entry_t              pend_reg,    pend_next;
    result_t             res_reg,     res_next;
    logic                out_v_reg,   out_v_next;
    result_t             out_reg,     out_next;

    logic out_free;
    logic hit;
    logic due;

    assign out_free = !out_v_reg || evt.ready;
    assign due      = !earlier(now_reg, rd_data_reg.deadline);

    // Compare unit: insert place for schedule, id match for cancel
    assign hit = cmp_v_reg &&
                 ((op_reg == ACT_SCHEDULE) ? earlier(dl_reg, rd_data_reg.deadline)
                                           : (rd_data_reg.id == tgt_reg));

    // Port drive
    assign cmd.ready        = (state_reg == S_IDLE);
    assign evt.valid        = out_v_reg;
    assign evt.kind         = out_reg.kind;
    assign evt.result_id    = out_reg.result_id;
    assign evt.fired_handle = out_reg.fired_handle;
    assign evt.fired_topic  = out_reg.fired_topic;
    assign evt.found        = out_reg.found;
    assign evt.last         = out_reg.last;

    // Next-state logic
    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        now_next     = now_reg;
        next_id_next = next_id_reg;
        cnt_next     = cnt_reg;
        head_next    = head_reg;
        dl_next      = dl_reg;
        tgt_next     = tgt_reg;
        hnd_next     = hnd_reg;
        top_next     = top_reg;
        idx_next     = idx_reg;
        cmp_v_next   = cmp_v_reg;
        cmp_idx_next = cmp_idx_reg;
        pos_next     = pos_reg;
        wr_v_next    = wr_v_reg;
        wr_idx_next  = wr_idx_reg;
        fire_n_next  = fire_n_reg;
        pend_v_next  = pend_v_reg;
        pend_next    = pend_reg;
        res_next     = res_reg;
        out_v_next   = out_v_reg && !evt.ready;
        out_next     = out_reg;

        rd_en   = 1'b0;
        rd_addr = head_reg;
        wr_en   = 1'b0;
        wr_addr = head_reg;
        wr_data = rd_data_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    op_next    = cmd.action;
                    idx_next   = '0;
                    cmp_v_next = 1'b0;
                    case (cmd.action)
                        ACT_SCHEDULE:
                        begin
                            if (cnt_reg >= CNT_W'(CAPACITY))
                            begin
                                res_next   = mk_res(KIND_FULL, '0, '0, '0, 1'b0, 1'b1);
                                state_next = S_DONE;
                            end
                            else
                            begin
                                dl_next    = now_reg + TIME_W'(cmd.delay);
                                hnd_next   = cmd.event_handle;
                                top_next   = cmd.topic;
                                state_next = S_SRCH;
                            end
                        end
                        ACT_CANCEL:
                        begin
                            tgt_next   = cmd.target_id;
                            state_next = S_SRCH;
                        end
                        ACT_TICK:
                        begin
                            now_next    = now_reg + 1'b1;
                            fire_n_next = '0;
                            pend_v_next = 1'b0;
                            state_next  = S_T_RD;
                        end
                        ACT_CLEAR:
                        begin
                            cnt_next   = '0;
                            res_next   = mk_res(KIND_CLEARED, '0, '0, '0, 1'b0, 1'b1);
                            state_next = S_DONE;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // Forward scan, one entry a cycle; the compare uses the registered read data
            S_SRCH:
            begin
                if (hit || (idx_reg == cnt_reg))
                begin
                    pos_next   = hit ? cmp_idx_reg : cnt_reg;
                    cmp_v_next = 1'b0;
                    wr_v_next  = 1'b0;
                    if (op_reg == ACT_SCHEDULE)
                    begin
                        idx_next   = cnt_reg;
                        state_next = S_SHUP;
                    end
                    else if (!hit)
                    begin
                        res_next   = mk_res(KIND_CANCEL, '0, '0, '0, 1'b0, 1'b1);
                        state_next = S_DONE;
                    end
                    else
                    begin
                        idx_next   = CNT_W'(cmp_idx_reg + 1'b1);
                        state_next = S_SHDN;
                    end
                end
                else
                begin
                    rd_en        = 1'b1;
                    rd_addr      = phys(head_reg, idx_reg);
                    cmp_v_next   = 1'b1;
                    cmp_idx_next = idx_reg;
                    idx_next     = CNT_W'(idx_reg + 1'b1);
                end
            end

            // Open a gap: move entries up by one, from the tail down to the insert place
            S_SHUP:
            begin
                if (wr_v_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = phys(head_reg, wr_idx_reg);
                    wr_data = rd_data_reg;
                end
                if (idx_reg > pos_reg)
                begin
                    rd_en       = 1'b1;
                    rd_addr     = phys(head_reg, CNT_W'(idx_reg - 1'b1));
                    wr_v_next   = 1'b1;
                    wr_idx_next = idx_reg;
                    idx_next    = CNT_W'(idx_reg - 1'b1);
                end
                else
                begin
                    wr_v_next  = 1'b0;
                    state_next = S_INS;
                end
            end

            // Drop the new entry into the gap
            S_INS:
            begin
                wr_en            = 1'b1;
                wr_addr          = phys(head_reg, pos_reg);
                wr_data.deadline = dl_reg;
                wr_data.id       = next_id_reg;
                wr_data.handle   = hnd_reg;
                wr_data.topic    = top_reg;
                cnt_next         = CNT_W'(cnt_reg + 1'b1);
                next_id_next     = next_id_reg + 1'b1;
                res_next         = mk_res(KIND_ACCEPTED, next_id_reg, '0, '0, 1'b0, 1'b1);
                state_next       = S_DONE;
            end

            // Close the hole: move entries down by one above the cancelled place
            S_SHDN:
            begin
                if (wr_v_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = phys(head_reg, wr_idx_reg);
                    wr_data = rd_data_reg;
                end
                if (idx_reg < cnt_reg)
                begin
                    rd_en       = 1'b1;
                    rd_addr     = phys(head_reg, idx_reg);
                    wr_v_next   = 1'b1;
                    wr_idx_next = CNT_W'(idx_reg - 1'b1);
                    idx_next    = CNT_W'(idx_reg + 1'b1);
                end
                else
                begin
                    wr_v_next  = 1'b0;
                    cnt_next   = CNT_W'(cnt_reg - 1'b1);
                    res_next   = mk_res(KIND_CANCEL, '0, '0, '0, 1'b1, 1'b1);
                    state_next = S_DONE;
                end
            end

            // Tick: read the front entry
            S_T_RD:
            begin
                if ((cnt_reg != '0) && (fire_n_reg != FIRE_W'(MAX_FIRE)))
                begin
                    rd_en      = 1'b1;
                    rd_addr    = head_reg;
                    state_next = S_T_CHK;
                end
                else
                begin
                    state_next = S_T_END;
                end
            end

            // Tick: pop a due front entry; the previous one goes out with last clear
            S_T_CHK:
            begin
                if (!due)
                begin
                    state_next = S_T_END;
                end
                else if (!pend_v_reg || out_free)
                begin
                    if (pend_v_reg)
                    begin
                        out_next   = mk_res(KIND_FIRED, pend_reg.id, pend_reg.handle,
                                            pend_reg.topic, 1'b0, 1'b0);
                        out_v_next = 1'b1;
                    end
                    pend_next   = rd_data_reg;
                    pend_v_next = 1'b1;
                    head_next   = phys(head_reg, CNT_W'(1));
                    cnt_next    = CNT_W'(cnt_reg - 1'b1);
                    fire_n_next = FIRE_W'(fire_n_reg + 1'b1);
                    state_next  = S_T_RD;
                end
            end

            // Tick: final beat is the held entry or nothing due
            S_T_END:
            begin
                if (pend_v_reg)
                begin
                    res_next = mk_res(KIND_FIRED, pend_reg.id, pend_reg.handle,
                                      pend_reg.topic, 1'b0, 1'b1);
                end
                else
                begin
                    res_next = mk_res(KIND_NONE, '0, '0, '0, 1'b0, 1'b1);
                end
                pend_v_next = 1'b0;
                state_next  = S_DONE;
            end

            // Hand the final beat to the output register
            S_DONE:
            begin
                if (out_free)
                begin
                    out_next   = res_reg;
                    out_v_next = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Store port: one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Sequencer and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            op_reg      <= ACT_SCHEDULE;
            now_reg     <= '0;
            next_id_reg <= '0;
            cnt_reg     <= '0;
            head_reg    <= '0;
            dl_reg      <= '0;
            tgt_reg     <= '0;
            hnd_reg     <= '0;
            top_reg     <= '0;
            idx_reg     <= '0;
            cmp_v_reg   <= 1'b0;
            cmp_idx_reg <= '0;
            pos_reg     <= '0;
            wr_v_reg    <= 1'b0;
            wr_idx_reg  <= '0;
            fire_n_reg  <= '0;
            pend_v_reg  <= 1'b0;
            pend_reg    <= '0;
            res_reg     <= '0;
            out_v_reg   <= 1'b0;
            out_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            now_reg     <= now_next;
            next_id_reg <= next_id_next;
            cnt_reg     <= cnt_next;
            head_reg    <= head_next;
            dl_reg      <= dl_next;
            tgt_reg     <= tgt_next;
            hnd_reg     <= hnd_next;
            top_reg     <= top_next;
            idx_reg     <= idx_next;
            cmp_v_reg   <= cmp_v_next;
            cmp_idx_reg <= cmp_idx_next;
            pos_reg     <= pos_next;
            wr_v_reg    <= wr_v_next;
            wr_idx_reg  <= wr_idx_next;
            fire_n_reg  <= fire_n_next;
            pend_v_reg  <= pend_v_next;
            pend_reg    <= pend_next;
            res_reg     <= res_next;
            out_v_reg   <= out_v_next;
            out_reg     <= out_next;
        end
    end

    // Checks
    `ASSERT_IMPL(a_cnt_bound, clk, rst_n, 1'b1, cnt_reg <= CNT_W'(CAPACITY))
    `ASSERT_IMPL(a_idle_no_pend, clk, rst_n, state_reg == S_IDLE, !pend_v_reg)
    `ASSERT_NEXT(a_id_step, clk, rst_n, state_reg == S_INS, next_id_reg == ID_W'($past(next_id_reg) + 1'b1))
    `ASSERT_IMPL(a_no_rw_clash, clk, rst_n, rd_en && wr_en, rd_addr != wr_addr)

endmodule

`default_nettype wire
